@@ hdl/cdm_pkg.sv @@
// Package for the CLEAN deconvolution minor-cycle block.
// Holds default sizes, the sequencer state type, mode codes and register indexes.
// Depends on nothing.
package cdm_pkg;

	localparam int IMAGE_DIM_DEF = 256;
	localparam int PSF_DIM_DEF   = 256;
	localparam int FRAC_BITS_DEF = 16;
	localparam int GAIN_BITS     = 16;
	localparam int DIM_W         = 9;
	localparam int COORD_W       = 8;
	localparam int PIX_W         = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int TGT_W         = 11;

	typedef enum logic [1:0] {
		MODE_LOAD_RES = 2'd0,
		MODE_LOAD_PSF = 2'd1,
		MODE_RUN      = 2'd2,
		MODE_READ     = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_PSF_WIDTH    = 3'd2,
		REG_PSF_HEIGHT   = 3'd3,
		REG_PSF_PEAK_COL = 3'd4,
		REG_PSF_PEAK_ROW = 3'd5,
		REG_LOOP_GAIN    = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_SCAN_END,
		ST_MUL,
		ST_INC,
		ST_UPD,
		ST_UPD_END,
		ST_MODEL_RD,
		ST_MODEL_WR
	} state_t;

endpackage

@@ hdl/clean_deconvolution_minor_cycle.sv @@
// Top level of the Hogbom CLEAN minor-cycle block.
// Depends on cdm_pkg and cdm_ram.
//
// A pixel load (residual or PSF) is written as it is accepted, and a pixel
// read passes through the READ state. A minor cycle first scans the active
// image once at one pixel per cycle, forms the gain product in the MUL and INC
// states, then walks the active PSF at one pixel per cycle through a pipelined
// multiply and subtract, and ends with a model update in MODEL_RD and MODEL_WR;
// the scan and the walk share the single read port of the residual memory.
// After reset the model memory is swept to zero, one pixel per cycle over all
// IMAGE_DIM*IMAGE_DIM entries, before the first transaction is taken.
module clean_deconvolution_minor_cycle
	import cdm_pkg::*;
#(
	parameter int IMAGE_DIM = IMAGE_DIM_DEF,
	parameter int PSF_DIM   = PSF_DIM_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// col [7:0], row [15:8], pixel_value [47:16]
	input  logic [47:0]           s_tdata,
	// mode [1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// peak_col [7:0], peak_row [15:8], peak_value [47:16], model_increment [79:48],
	// residual_out [111:80], model_out [143:112]
	output logic [143:0]          m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int IMG_DEPTH = IMAGE_DIM * IMAGE_DIM;
	localparam int PSF_DEPTH = PSF_DIM * PSF_DIM;
	localparam int IAW       = $clog2(IMG_DEPTH);
	localparam int PAW       = $clog2(PSF_DEPTH);
	localparam int PROD_W    = 2 * PIX_W;

	function automatic logic [IAW-1:0] img_addr(input int r, input int c);
		return IAW'(r * IMAGE_DIM + c);
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int dim);
		logic [DIM_W-1:0] res;
		if (v == '0) begin
			res = DIM_W'(1);
		end else if (int'(v) > dim) begin
			res = DIM_W'(dim);
		end else begin
			res = v;
		end
		return res;
	endfunction

	function automatic logic signed [PIX_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PIX_W-1:0] res;
		if (v > PROD_W'(64'sh7FFF_FFFF)) begin
			res = {1'b0, {(PIX_W-1){1'b1}}};
		end else if (v < -PROD_W'(64'sh8000_0000)) begin
			res = {1'b1, {(PIX_W-1){1'b0}}};
		end else begin
			res = v[PIX_W-1:0];
		end
		return res;
	endfunction

	// Configuration registers.
	logic [DIM_W-1:0]   img_w_q, img_h_q, psf_w_q, psf_h_q;
	logic [COORD_W-1:0] peak_c_q, peak_r_q;
	logic [GAIN_BITS-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q  <= DIM_W'(256);
			img_h_q  <= DIM_W'(256);
			psf_w_q  <= DIM_W'(256);
			psf_h_q  <= DIM_W'(256);
			peak_c_q <= '0;
			peak_r_q <= '0;
			gain_q   <= GAIN_BITS'(655);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  img_w_q  <= cfg_wdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: img_h_q  <= cfg_wdata[DIM_W-1:0];
				REG_PSF_WIDTH:    psf_w_q  <= cfg_wdata[DIM_W-1:0];
				REG_PSF_HEIGHT:   psf_h_q  <= cfg_wdata[DIM_W-1:0];
				REG_PSF_PEAK_COL: peak_c_q <= cfg_wdata[COORD_W-1:0];
				REG_PSF_PEAK_ROW: peak_r_q <= cfg_wdata[COORD_W-1:0];
				REG_LOOP_GAIN:    gain_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [DIM_W-1:0] w, h, pw, ph;
	assign w  = clamp_dim(img_w_q, IMAGE_DIM);
	assign h  = clamp_dim(img_h_q, IMAGE_DIM);
	assign pw = clamp_dim(psf_w_q, PSF_DIM);
	assign ph = clamp_dim(psf_h_q, PSF_DIM);

	// Input fields.
	logic [1:0]              in_mode;
	logic [COORD_W-1:0]      in_col, in_row;
	logic [PIX_W-1:0]        in_pix;
	logic                    in_img_ok, in_psf_ok, accept;
	assign in_mode   = s_tuser;
	assign in_col    = s_tdata[7:0];
	assign in_row    = s_tdata[15:8];
	assign in_pix    = s_tdata[47:16];
	assign in_img_ok = (int'(in_col) < IMAGE_DIM) && (int'(in_row) < IMAGE_DIM);
	assign in_psf_ok = (int'(in_col) < PSF_DIM) && (int'(in_row) < PSF_DIM);
	assign accept    = s_tvalid && s_tready;

	state_t state_q, state_d;

	logic [IAW-1:0]     clr_q;
	logic [DIM_W-1:0]   sx_q, sy_q, ux_q, uy_q;
	logic               rd_ok_q, first_q;
	logic               sv_s1;
	logic [COORD_W-1:0] sx_s1, sy_s1;
	logic [PIX_W-1:0]   best_mag_q;
	logic signed [PIX_W-1:0] best_val_q, inc_q;
	logic [COORD_W-1:0] bx_q, by_q;
	logic signed [GAIN_BITS+PIX_W:0] gprod_q;
	logic               uv_s1, uv_s2, uv_s3;
	logic [IAW-1:0]     ua_s1, ua_s2, ua_s3;
	logic signed [PROD_W-1:0] prod_s2, d_s3;
	logic signed [PIX_W-1:0]  res_s2, res_s3;
	logic               out_valid_q;
	logic [143:0]       out_data_q;

	// Memory ports.
	logic              res_we, psf_we, mdl_we;
	logic [IAW-1:0]    res_wa, res_ra, mdl_wa, mdl_ra;
	logic [PAW-1:0]    psf_ra;
	logic [PIX_W-1:0]  res_wd, mdl_wd, res_rd, psf_rd, mdl_rd;

	cdm_ram #(.WIDTH(PIX_W), .DEPTH(IMG_DEPTH)) u_res_ram (
		.clk(clk), .we(res_we), .waddr(res_wa), .wdata(res_wd), .raddr(res_ra), .rdata(res_rd)
	);
	cdm_ram #(.WIDTH(PIX_W), .DEPTH(PSF_DEPTH)) u_psf_ram (
		.clk(clk), .we(psf_we), .waddr(PAW'(int'(in_row) * PSF_DIM + int'(in_col))),
		.wdata(in_pix), .raddr(psf_ra), .rdata(psf_rd)
	);
	cdm_ram #(.WIDTH(PIX_W), .DEPTH(IMG_DEPTH)) u_mdl_ram (
		.clk(clk), .we(mdl_we), .waddr(mdl_wa), .wdata(mdl_wd), .raddr(mdl_ra), .rdata(mdl_rd)
	);

	// Target pixel of the current PSF pixel.
	logic signed [TGT_W-1:0] tx, ty;
	logic                    t_ok;
	assign tx   = $signed({3'b0, bx_q}) - $signed({3'b0, peak_c_q}) + $signed({2'b0, ux_q});
	assign ty   = $signed({3'b0, by_q}) - $signed({3'b0, peak_r_q}) + $signed({2'b0, uy_q});
	assign t_ok = (tx >= 0) && (ty >= 0) && (tx < $signed({2'b0, w})) && (ty < $signed({2'b0, h}));

	logic [PIX_W-1:0] mag;
	assign mag = res_rd[PIX_W-1] ? (~res_rd + PIX_W'(1)) : res_rd;

	logic scan_last, upd_last;
	assign scan_last = (sx_q == w - DIM_W'(1)) && (sy_q == h - DIM_W'(1));
	assign upd_last  = (ux_q == pw - DIM_W'(1)) && (uy_q == ph - DIM_W'(1));

	logic signed [PIX_W:0] mdl_sum;
	assign mdl_sum = $signed({mdl_rd[PIX_W-1], mdl_rd}) + $signed({inc_q[PIX_W-1], inc_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		res_we   = 1'b0;
		res_wa   = img_addr(int'(in_row), int'(in_col));
		res_wd   = in_pix;
		res_ra   = img_addr(int'(in_row), int'(in_col));
		psf_we   = 1'b0;
		psf_ra   = PAW'(int'(uy_q) * PSF_DIM + int'(ux_q));
		mdl_we   = 1'b0;
		mdl_wa   = clr_q;
		mdl_wd   = '0;
		mdl_ra   = img_addr(int'(in_row), int'(in_col));
		if (uv_s3) begin
			res_we = 1'b1;
			res_wa = ua_s3;
			res_wd = sat32(PROD_W'(res_s3) - d_s3);
		end
		unique case (state_q)
			ST_CLEAR: begin
				mdl_we = 1'b1;
				if (int'(clr_q) == IMG_DEPTH - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = !out_valid_q || m_tready;
				if (accept) begin
					case (in_mode)
						MODE_LOAD_RES: res_we = in_img_ok;
						MODE_LOAD_PSF: psf_we = in_psf_ok;
						MODE_RUN:      state_d = ST_SCAN;
						default:       state_d = ST_READ;
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				res_ra = img_addr(int'(sy_q), int'(sx_q));
				if (scan_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: state_d = ST_MUL;
			ST_MUL:      state_d = ST_INC;
			ST_INC:      state_d = ST_UPD;
			ST_UPD: begin
				res_ra = img_addr(int'(ty), int'(tx));
				if (upd_last) begin
					state_d = ST_UPD_END;
				end
			end
			ST_UPD_END: begin
				if (!uv_s1 && !uv_s2 && !uv_s3) begin
					state_d = ST_MODEL_RD;
				end
			end
			ST_MODEL_RD: begin
				mdl_ra  = img_addr(int'(by_q), int'(bx_q));
				state_d = ST_MODEL_WR;
			end
			ST_MODEL_WR: begin
				mdl_we  = 1'b1;
				mdl_wa  = img_addr(int'(by_q), int'(bx_q));
				mdl_wd  = sat32(PROD_W'(mdl_sum));
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			ux_q        <= '0;
			uy_q        <= '0;
			first_q     <= 1'b0;
			sv_s1       <= 1'b0;
			uv_s1       <= 1'b0;
			uv_s2       <= 1'b0;
			uv_s3       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IAW'(1);
			end
			sv_s1 <= (state_q == ST_SCAN);
			uv_s1 <= (state_q == ST_UPD) && t_ok;
			uv_s2 <= uv_s1;
			uv_s3 <= uv_s2;
			if (accept && in_mode == MODE_RUN) begin
				sx_q    <= '0;
				sy_q    <= '0;
				first_q <= 1'b1;
			end else if (state_q == ST_SCAN) begin
				if (sx_q == w - DIM_W'(1)) begin
					sx_q <= '0;
					sy_q <= sy_q + DIM_W'(1);
				end else begin
					sx_q <= sx_q + DIM_W'(1);
				end
			end
			if (sv_s1) begin
				first_q <= 1'b0;
			end
			if (state_q == ST_INC) begin
				ux_q <= '0;
				uy_q <= '0;
			end else if (state_q == ST_UPD) begin
				if (ux_q == pw - DIM_W'(1)) begin
					ux_q <= '0;
					uy_q <= uy_q + DIM_W'(1);
				end else begin
					ux_q <= ux_q + DIM_W'(1);
				end
			end
			if (state_q == ST_READ || state_q == ST_MODEL_WR) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		sx_s1 <= sx_q[COORD_W-1:0];
		sy_s1 <= sy_q[COORD_W-1:0];
		if (accept) begin
			rd_ok_q <= in_img_ok;
		end
		if (sv_s1 && (first_q || mag > best_mag_q)) begin
			best_mag_q <= mag;
			best_val_q <= res_rd;
			bx_q       <= sx_s1;
			by_q       <= sy_s1;
		end
		if (state_q == ST_MUL) begin
			gprod_q <= $signed({1'b0, gain_q}) * best_val_q;
		end
		if (state_q == ST_INC) begin
			inc_q <= PIX_W'((gprod_q + (GAIN_BITS+PIX_W+1)'(1 << (GAIN_BITS-1))) >>> GAIN_BITS);
		end
		ua_s1   <= img_addr(int'(ty), int'(tx));
		prod_s2 <= $signed(psf_rd) * inc_q;
		res_s2  <= res_rd;
		ua_s2   <= ua_s1;
		d_s3    <= (prod_s2 + (PROD_W'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
		res_s3  <= res_s2;
		ua_s3   <= ua_s2;
		if (state_q == ST_READ) begin
			out_data_q <= rd_ok_q ? {mdl_rd, res_rd, 80'd0} : '0;
		end else if (state_q == ST_MODEL_WR) begin
			out_data_q <= {64'd0, inc_q, best_val_q, by_q, bx_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("input taken outside idle");
	a_no_write_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SCAN_END) |-> !res_we)
		else $error("residual written during peak search");
	a_result_after_model: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MODEL_WR |=> m_tvalid)
		else $error("minor cycle ended without a result");
	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> (sx_q < w && sy_q < h))
		else $error("scan left the active image");

endmodule

@@ hdl/cdm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the residual, PSF and model stores; depends on nothing.
module cdm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
